>>> rtl/core/spl_pkg.sv
// ============================================================================
// spl_pkg
// Types and constants shared by the servo position link engine.
// ============================================================================
package spl_pkg;

  // input op codes
  localparam logic [1:0] OP_RX    = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_HOLD  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_FRAME = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;

  localparam logic [7:0] TX_ID_MARK     = 8'h80;
  localparam logic [1:0] FRAME_LAST_IDX = 2'd2;
  localparam logic [3:0] SERVO_COUNT_RST = 4'd1;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  rx_byte;
    logic [2:0]  slot;
    logic [4:0]  slot_id;
    logic [13:0] goal_in;
    logic        torque_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [4:0]  report_id;
    logic [13:0] report_position;
    logic        matched;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_ACK,
    CMD_FRAME,
    CMD_TICK,
    CMD_WRITE,
    CMD_HOLD
  } cmd_code_t;

  // bus_id/value carry the decoded id/position for CMD_FRAME
  typedef struct packed {
    cmd_code_t   code;
    logic [2:0]  slot;
    logic [4:0]  bus_id;
    logic [13:0] value;
    logic        torque;
  } cmd_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [Q_CNT_W-1:0] count;
  } q_status_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

>>> rtl/core/servo_position_link_engine.sv
// ============================================================================
// servo_position_link_engine
// Servo slot table with round-robin position frames out, receive frame decode.
// ============================================================================
// The first result is registered after the item has passed the command queue
// and the command register. In the back-end sequencer a single-result item
// is a command pop, then a result beat; a send tick is a pop, then tx beats
// for the id and both position bytes. An empty-count tick is dropped at pop.
// Reset (rst_n, synchronous, active low): slot table, frame assembler, queue,
// pointer and output cleared; servo_count returns to 1.
module servo_position_link_engine #(
  parameter int SLOT_COUNT = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration: servo_count
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  spl_pkg::in_item_t  in_item,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output spl_pkg::out_item_t out_item
);
  import spl_pkg::*;

  logic      [3:0] servo_count_r;
  logic            q_ready;
  logic            q_push;
  cmd_t            q_push_cmd;
  logic            q_pop;
  logic            q_valid;
  cmd_t            q_pop_cmd;
  q_status_t       q_stat;

  // servo_count: user must write it only while the engine is idle; not enforced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servo_count_r <= SERVO_COUNT_RST;
    end else if (cfg_we) begin
      servo_count_r <= cfg_wdata;
    end
  end

  // front: accepts items, assembles 3-byte rx frames, classifies into commands
  spl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_cmd    (q_push_cmd)
  );

  // two-entry command queue decouples intake from execution
  spl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_cmd    (q_pop_cmd),
    .status     (q_stat)
  );

  // back: slot table, round-robin sender, result register
  spl_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .servo_count (servo_count_r),
    .q_valid     (q_valid),
    .q_cmd       (q_pop_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

  // ---------------------------------------------------------------- checks
  // only tx beats may be non-final
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.kind != KIND_TX) |-> out_item.last)
    else $error("non-tx result without last");

  // matched only appears on frame reports
  a_matched_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.matched |-> (out_item.kind == KIND_FRAME))
    else $error("matched set outside frame report");

  // queue occupancy bounded and front stalls when full
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.count <= Q_CNT_W'(Q_DEPTH)) && (!q_stat.full || !in_ready))
    else $error("queue occupancy or backpressure broken");

  // reset empties the result register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

>>> rtl/core/spl_front.sv
// ============================================================================
// spl_front
// Accepts input items, assembles receive frames and issues back-end commands.
// ============================================================================
module spl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  spl_pkg::in_item_t in_item,
  input  logic              q_ready,
  output logic              q_push,
  output spl_pkg::cmd_t     q_cmd
);
  import spl_pkg::*;

  logic [1:0] fidx_r;
  logic [1:0] fidx_nxt;
  logic [7:0] byte0_r;
  logic [7:0] byte1_r;
  logic       frame_done;

  assign in_ready   = q_ready;
  assign q_push     = in_valid && q_ready;
  assign frame_done = (fidx_r == FRAME_LAST_IDX);
  assign fidx_nxt   = fidx_r + 2'd1;

  always_comb begin
    q_cmd        = '0;
    q_cmd.slot   = in_item.slot;
    q_cmd.bus_id = in_item.slot_id;
    q_cmd.value  = in_item.goal_in;
    q_cmd.torque = in_item.torque_in;
    unique case (in_item.op)
      OP_RX: begin
        if (frame_done) begin
          q_cmd.code   = CMD_FRAME;
          q_cmd.bus_id = byte0_r[4:0];
          q_cmd.value  = {byte1_r[6:0], in_item.rx_byte[6:0]};
        end else begin
          q_cmd.code = CMD_ACK;
        end
      end
      OP_TICK:  q_cmd.code = CMD_TICK;
      OP_WRITE: q_cmd.code = CMD_WRITE;
      OP_HOLD:  q_cmd.code = CMD_HOLD;
      default:  q_cmd.code = CMD_ACK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fidx_r  <= '0;
      byte0_r <= '0;
      byte1_r <= '0;
    end else if (q_push && (in_item.op == OP_RX)) begin
      if (frame_done) begin
        fidx_r  <= '0;
        byte0_r <= '0;
        byte1_r <= '0;
      end else begin
        if (fidx_r == 2'd0) begin
          byte0_r <= in_item.rx_byte;
        end else begin
          byte1_r <= in_item.rx_byte;
        end
        fidx_r <= fidx_nxt;
      end
    end
  end

endmodule

>>> rtl/core/spl_queue.sv
// ============================================================================
// spl_queue
// Short command queue between the front and back parts.
// ============================================================================
module spl_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  spl_pkg::cmd_t       push_cmd,
  output logic                push_ready,
  input  logic                pop,
  output logic                pop_valid,
  output spl_pkg::cmd_t       pop_cmd,
  output spl_pkg::q_status_t  status
);
  import spl_pkg::*;

  cmd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;
  logic               do_push;
  logic               do_pop;

  assign status.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign status.empty = (count_r == '0);
  assign status.count = count_r;

  assign push_ready = !status.full;
  assign pop_valid  = !status.empty;
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push && !status.full;
  assign do_pop     = pop && !status.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - Q_CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/core/spl_back.sv
// ============================================================================
// spl_back
// Executes commands against the slot table and drives the result register.
// ============================================================================
module spl_back #(
  parameter int SLOT_COUNT = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [3:0]         servo_count,
  input  logic               q_valid,
  input  spl_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output spl_pkg::out_item_t out_item
);
  import spl_pkg::*;

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = ($clog2(SLOT_COUNT + 1) > 4) ? $clog2(SLOT_COUNT + 1) : 4;

  back_state_t state_r;
  back_state_t state_nxt;
  cmd_t        cmd_r;
  logic [1:0]  beat_r;
  logic [IW-1:0] next_slot_r;

  logic [4:0]  id_r      [SLOT_COUNT];
  logic        torque_r  [SLOT_COUNT];
  logic [13:0] goal_r    [SLOT_COUNT];
  logic [13:0] present_r [SLOT_COUNT];

  logic        out_valid_r;
  out_item_t   out_r;
  out_item_t   out_nxt;

  logic [CW-1:0] cnt;
  logic [IW-1:0] cur;
  logic [CW-1:0] cur_inc;
  logic [IW-1:0] next_slot_nxt;
  logic          s_ok;
  logic [IW-1:0] s_idx;
  logic [IW-1:0] rd_idx;
  logic [4:0]    rd_id;
  logic          rd_torque;
  logic [13:0]   rd_goal;
  logic [13:0]   rd_present;
  logic [13:0]   tick_val;
  logic [SLOT_COUNT-1:0] hit_vec;
  logic          take;
  logic          drop;
  logic          emit;
  logic          last_beat;

  // active slot count, clipped to the table size
  assign cnt = (CW'(servo_count) > CW'(SLOT_COUNT)) ? CW'(SLOT_COUNT) : CW'(servo_count);
  // stale pointer after the count was lowered restarts at slot 0
  assign cur           = (CW'(next_slot_r) < cnt) ? next_slot_r : '0;
  assign cur_inc       = CW'(cur) + CW'(1);
  assign next_slot_nxt = (cur_inc == cnt) ? '0 : IW'(cur_inc);

  assign s_ok  = (32'(cmd_r.slot) < SLOT_COUNT);
  assign s_idx = IW'(cmd_r.slot);

  assign rd_idx     = (cmd_r.code == CMD_TICK) ? cur : s_idx;
  assign rd_id      = id_r[rd_idx];
  assign rd_torque  = torque_r[rd_idx];
  assign rd_goal    = goal_r[rd_idx];
  assign rd_present = present_r[rd_idx];
  assign tick_val   = rd_torque ? rd_goal : '0;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit_vec[i] = (CW'(i) < cnt) && (id_r[i] == cmd_r.bus_id);
    end
  end

  assign take      = (state_r == BK_IDLE) && q_valid;
  assign drop      = (q_cmd.code == CMD_TICK) && (cnt == '0);
  assign q_pop     = take;
  assign emit      = (state_r == BK_RUN) && (!out_valid_r || out_ready);
  assign last_beat = (cmd_r.code != CMD_TICK) || (beat_r == 2'd2);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (take && !drop) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (emit && last_beat) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // result of the current beat
  always_comb begin
    out_nxt      = '0;
    out_nxt.kind = KIND_ACK;
    out_nxt.last = 1'b1;
    unique case (cmd_r.code)
      CMD_FRAME: begin
        out_nxt.kind            = KIND_FRAME;
        out_nxt.report_id       = cmd_r.bus_id;
        out_nxt.report_position = cmd_r.value;
        out_nxt.matched         = |hit_vec;
      end
      CMD_TICK: begin
        out_nxt.kind = KIND_TX;
        out_nxt.last = (beat_r == 2'd2);
        case (beat_r)
          2'd0:    out_nxt.tx_byte = TX_ID_MARK + {3'b000, rd_id};
          2'd1:    out_nxt.tx_byte = {1'b0, tick_val[13:7]};
          default: out_nxt.tx_byte = {1'b0, tick_val[6:0]};
        endcase
      end
      CMD_HOLD: begin
        out_nxt.report_position = s_ok ? rd_present : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      beat_r      <= '0;
      next_slot_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        id_r[i]      <= '0;
        torque_r[i]  <= 1'b0;
        goal_r[i]    <= '0;
        present_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (take) begin
        beat_r <= '0;
      end else if (emit) begin
        beat_r <= beat_r + 2'd1;
      end

      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (emit) begin
        case (cmd_r.code)
          CMD_FRAME: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (hit_vec[i]) begin
                present_r[i] <= cmd_r.value;
              end
            end
          end
          CMD_WRITE: begin
            if (s_ok) begin
              id_r[s_idx]     <= cmd_r.bus_id;
              goal_r[s_idx]   <= cmd_r.value;
              torque_r[s_idx] <= cmd_r.torque;
            end
          end
          CMD_HOLD: begin
            if (s_ok && rd_torque) begin
              goal_r[s_idx] <= rd_present;
            end
          end
          CMD_TICK: begin
            if (last_beat) begin
              next_slot_r <= next_slot_nxt;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= q_cmd;
    end
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> sim/tb_servo_position_link_engine.sv
// ----------------------------------------------------------------------------
// tb_servo_position_link_engine
// Self-checking bench for the servo slot table and position frame link.
// Items go through a queue-fed valid/ready driver. Each accepted item runs
// through a local slot-table model, which queues the results it predicts.
// A monitor pops one prediction per accepted result and checks every field.
// Phases at several servo counts (0, 1, 2, 3, 5, 8, 15 and random) cover the
// directed corner cases and random frame/tick/write/hold traffic. Both sides
// idle at random, and there is one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_servo_position_link_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import spl_pkg::*;

  localparam int SLOTS     = 8;
  localparam int FRAME_LEN = 3;
  localparam int LIMIT     = 100000;  // cycles

  // --------------------------------------------------------------------------
  // clock, reset, DUT ports; every input is known from time zero
  // --------------------------------------------------------------------------
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic [3:0] cfg_wdata = 4'd0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  always #10 clk = ~clk;

  servo_position_link_engine #(.SLOT_COUNT(SLOTS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  // --------------------------------------------------------------------------
  // bench state
  // --------------------------------------------------------------------------
  in_item_t  pending_items[$];    // stimulus waiting for the driver
  out_item_t awaited_results[$];  // predicted results, oldest first
  int        err_count   = 0;
  int        idle_pct    = 0;     // chance per decision that a side idles
  int        send_gap    = 0;
  int        recv_gap    = 0;
  int        hold_left   = 0;     // long receiver hold-off countdown
  logic      stall_req   = 1'b0;
  logic      hold_done   = 1'b0;
  out_item_t want;

  // slot table model
  logic [4:0]  m_id[SLOTS];
  logic        m_torque[SLOTS];
  logic [13:0] m_goal[SLOTS];
  logic [13:0] m_present[SLOTS];
  logic [7:0]  m_frame[2];
  logic [1:0]  m_frame_pos;
  logic [2:0]  m_next;
  logic [3:0]  m_count;

  // generator bookkeeping: frame phase of queued rx bytes and the ids written
  int          gen_frame_pos = 0;
  int          queued_total  = 0;
  logic [4:0]  gen_ids[SLOTS];

  // --------------------------------------------------------------------------
  // model: apply one accepted item, queue the results it causes
  // --------------------------------------------------------------------------
  task automatic predict_servo_results(input in_item_t it);
    int          act;
    int          cur;
    int          i;
    logic [13:0] val;
    logic [13:0] pos;
    logic [4:0]  fid;
    logic        hit;
    out_item_t   r;
    act = (m_count > SLOTS) ? SLOTS : int'(m_count);
    r = '0;
    r.kind = KIND_ACK;
    r.last = 1'b1;
    case (it.op)
      OP_RX: begin
        if (m_frame_pos < FRAME_LAST_IDX) begin
          m_frame[m_frame_pos] = it.rx_byte;
          m_frame_pos = m_frame_pos + 2'd1;
          awaited_results.push_back(r);
        end else begin
          // third byte closes the frame: id from byte 0, 7+7 position bits
          fid = m_frame[0][4:0];
          pos = {m_frame[1][6:0], it.rx_byte[6:0]};
          hit = 1'b0;
          for (i = 0; i < act; i++) begin
            if (m_id[i] == fid) begin
              m_present[i] = pos;
              hit = 1'b1;
            end
          end
          m_frame[0] = '0;
          m_frame[1] = '0;
          m_frame_pos = '0;
          r.kind = KIND_FRAME;
          r.report_id = fid;
          r.report_position = pos;
          r.matched = hit;
          awaited_results.push_back(r);
        end
      end
      OP_TICK: begin
        if (act != 0) begin
          // a pointer left over from a larger count wraps to slot 0
          cur = (int'(m_next) < act) ? int'(m_next) : 0;
          val = m_torque[cur] ? m_goal[cur] : 14'd0;
          r.kind = KIND_TX;
          r.last = 1'b0;
          r.tx_byte = TX_ID_MARK + {3'd0, m_id[cur]};
          awaited_results.push_back(r);
          r.tx_byte = {1'b0, val[13:7]};
          awaited_results.push_back(r);
          r.tx_byte = {1'b0, val[6:0]};
          r.last = 1'b1;
          awaited_results.push_back(r);
          m_next = 3'((cur + 1) % act);
        end
      end
      OP_WRITE: begin
        m_id[it.slot] = it.slot_id;
        m_goal[it.slot] = it.goal_in;
        m_torque[it.slot] = it.torque_in;
        awaited_results.push_back(r);
      end
      OP_HOLD: begin
        r.report_position = m_present[it.slot];
        if (m_torque[it.slot]) m_goal[it.slot] = m_present[it.slot];
        awaited_results.push_back(r);
      end
    endcase
  endtask

  function automatic void field_check(input string name, input logic [13:0] exp_v,
                                      input logic [13:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      err_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // driver: an item is handed over when the slot is free; the model runs on
  // the item at the edge where it is taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) predict_servo_results(in_item);
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        in_valid <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        // idle burst of random length
        send_gap <= $urandom_range(0, 4);
        in_valid <= 1'b0;
      end else begin
        in_item  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // long hold-off: once requested, the receiver stays off for a stretch so
  // the internal queue fills and in_ready drops
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (stall_req && !hold_done) begin
      hold_left <= 90;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: check each accepted result against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result with nothing expected: kind %0d tx %0h", out_item.kind,
                 out_item.tx_byte);
          err_count++;
        end else begin
          want = awaited_results.pop_front();
          field_check("kind", 14'(want.kind), 14'(out_item.kind));
          field_check("tx_byte", 14'(want.tx_byte), 14'(out_item.tx_byte));
          field_check("last", 14'(want.last), 14'(out_item.last));
          field_check("report_id", 14'(want.report_id), 14'(out_item.report_id));
          field_check("report_position", want.report_position, out_item.report_position);
          field_check("matched", 14'(want.matched), 14'(out_item.matched));
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap  <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        recv_gap  <= $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic in_item_t item_of(input logic [1:0] op, input logic [7:0] rx,
                                       input logic [2:0] slot, input logic [4:0] id,
                                       input logic [13:0] goal, input logic torque);
    in_item_t it;
    it.op = op;
    it.rx_byte = rx;
    it.slot = slot;
    it.slot_id = id;
    it.goal_in = goal;
    it.torque_in = torque;
    return it;
  endfunction

  // all fields random, unused ones included; goals lean toward the extremes
  function automatic in_item_t noise_item(input logic [1:0] op);
    in_item_t it;
    it.op = op;
    it.rx_byte = 8'($urandom_range(0, 255));
    it.slot = 3'($urandom_range(0, SLOTS - 1));
    it.slot_id = 5'($urandom_range(0, 31));
    it.torque_in = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0:       it.goal_in = 14'd0;
      1:       it.goal_in = 14'h3fff;
      default: it.goal_in = 14'($urandom_range(0, 16383));
    endcase
    return it;
  endfunction

  task automatic queue_item(input in_item_t it);
    pending_items.push_back(it);
    queued_total++;
    if (it.op == OP_RX) gen_frame_pos = (gen_frame_pos + 1) % FRAME_LEN;
    if (it.op == OP_WRITE) gen_ids[it.slot] = it.slot_id;
  endtask

  // whole frames, mostly with an id that hits a written slot; the rest ticks, writes,
  // holds and stray bytes that shift the frame phase
  task automatic queue_random(input int n);
    int       stop_at;
    int       pick;
    in_item_t it;
    stop_at = queued_total + n;
    while (queued_total < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        while (gen_frame_pos != 0) queue_item(noise_item(OP_RX));
        it = noise_item(OP_RX);
        if ($urandom_range(0, 4) != 0) it.rx_byte[4:0] = gen_ids[$urandom_range(0, SLOTS - 1)];
        queue_item(it);
        queue_item(noise_item(OP_RX));
        queue_item(noise_item(OP_RX));
      end else if (pick < 42) begin
        queue_item(noise_item(OP_RX));
      end else if (pick < 67) begin
        queue_item(noise_item(OP_TICK));
      end else if (pick < 82) begin
        it = noise_item(OP_WRITE);
        if ($urandom_range(0, 1) != 0) it.slot_id = 5'($urandom_range(0, 3));
        queue_item(it);
      end else begin
        queue_item(noise_item(OP_HOLD));
      end
    end
  endtask

  // wait until everything sent has been answered, then let a dropped tick
  // (no result) clear the back end
  task automatic settle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || awaited_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_servo_count(input logic [3:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    m_count = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // run-time limit
  // --------------------------------------------------------------------------
  int cycle_count = 0;
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      m_id[i] = '0;
      m_torque[i] = 1'b0;
      m_goal[i] = '0;
      m_present[i] = '0;
      gen_ids[i] = '0;
    end
    m_frame[0] = '0;
    m_frame[1] = '0;
    m_frame_pos = '0;
    m_next = '0;
    m_count = SERVO_COUNT_RST;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    idle_pct = 25;

    // directed, count 1 out of reset
    queue_item(item_of(OP_TICK, 8'h00, 3'd0, 5'd0, 14'd0, 1'b0));       // all-zero slot
    queue_item(item_of(OP_WRITE, 8'hff, 3'd0, 5'd31, 14'h3fff, 1'b1));
    queue_item(item_of(OP_TICK, 8'hff, 3'd7, 5'd31, 14'h3fff, 1'b1));   // 9f 7f 7f
    queue_item(item_of(OP_WRITE, 8'h00, 3'd1, 5'd5, 14'h2aaa, 1'b1));
    queue_item(item_of(OP_RX, 8'hff, 3'd0, 5'd0, 14'd0, 1'b0));         // id 31, top bits dropped
    queue_item(item_of(OP_RX, 8'hff, 3'd0, 5'd0, 14'd0, 1'b0));
    queue_item(item_of(OP_RX, 8'hff, 3'd0, 5'd0, 14'd0, 1'b0));         // matches slot 0
    queue_item(item_of(OP_RX, 8'h05, 3'd0, 5'd0, 14'd0, 1'b0));
    queue_item(item_of(OP_RX, 8'h00, 3'd0, 5'd0, 14'd0, 1'b0));
    queue_item(item_of(OP_RX, 8'h00, 3'd0, 5'd0, 14'd0, 1'b0));         // slot 1 not active
    queue_item(item_of(OP_HOLD, 8'h00, 3'd0, 5'd0, 14'd0, 1'b0));       // torque on: goal follows
    queue_item(item_of(OP_HOLD, 8'h00, 3'd7, 5'd0, 14'd0, 1'b0));       // torque off
    queue_item(item_of(OP_RX, 8'he0, 3'd0, 5'd0, 14'd0, 1'b0));
    queue_item(item_of(OP_RX, 8'h80, 3'd0, 5'd0, 14'd0, 1'b0));
    queue_item(item_of(OP_RX, 8'h80, 3'd0, 5'd0, 14'd0, 1'b0));         // id 0, no match

    // no active slots: tick gives nothing
    set_servo_count(4'd0);
    queue_item(item_of(OP_TICK, 8'h00, 3'd0, 5'd0, 14'd0, 1'b0));
    queue_item(item_of(OP_RX, 8'h1f, 3'd0, 5'd0, 14'd0, 1'b0));

    // full table; close the open frame, walk the pointer up
    set_servo_count(4'd8);
    queue_item(item_of(OP_RX, 8'h40, 3'd0, 5'd0, 14'd0, 1'b0));
    queue_item(item_of(OP_RX, 8'h01, 3'd0, 5'd0, 14'd0, 1'b0));
    repeat (5) queue_item(item_of(OP_TICK, 8'h00, 3'd0, 5'd0, 14'd0, 1'b0));

    // count above the table size acts as the table size
    set_servo_count(4'd15);
    repeat (2) queue_item(item_of(OP_TICK, 8'h00, 3'd0, 5'd0, 14'd0, 1'b0));

    // pointer at 7 is stale once the count drops to 3
    set_servo_count(4'd3);
    queue_item(item_of(OP_TICK, 8'h00, 3'd0, 5'd0, 14'd0, 1'b0));

    // random traffic, full table, with the long hold-off partway in
    set_servo_count(4'd8);
    idle_pct = 30;
    queue_random(50);
    stall_req <= 1'b1;

    set_servo_count(4'($urandom_range(1, 15)));
    idle_pct = 50;
    queue_random(40);

    set_servo_count(4'd2);
    idle_pct = 10;
    queue_random(20);

    // closing stretch with no idling on either side
    set_servo_count(4'd5);
    idle_pct = 0;
    queue_random(30);

    settle();
    repeat (20) @(posedge clk);
    if (err_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/spl_pkg.sv
rtl/core/spl_front.sv
rtl/core/spl_queue.sv
rtl/core/spl_back.sv
rtl/core/servo_position_link_engine.sv
sim/tb_servo_position_link_engine.sv
